[rtl/core/ntfsrl_pkg.sv]
// Package for the NTFS run list decoder: word widths, phase codes and size limits.
// Used by the decoder top level and by its checker. No dependencies.
package ntfsrl_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 64;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CountW = 4;
  localparam int unsigned PosW   = 3;
  localparam int unsigned Lanes  = WordW / ByteW;

  // Largest legal value of either size nibble in a header byte.
  localparam logic [CountW-1:0] SizeMax = 4'd8;

  // Decoder phase codes.
  localparam logic [PhaseW-1:0] PH_HEADER = 2'd0;
  localparam logic [PhaseW-1:0] PH_LENGTH = 2'd1;
  localparam logic [PhaseW-1:0] PH_OFFSET = 2'd2;
  localparam logic [PhaseW-1:0] PH_HALTED = 2'd3;

endpackage

[rtl/core/ntfs_run_list_decoder.sv]
// NTFS mapping-pairs run list decoder, one stream byte per word.
// Depends on ntfsrl_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one byte of the
//   mapping-pairs stream per word, with list_start_i marking the first
//   header of a new run list. The output channel (out_valid_o /
//   out_stall_i) carries one word per decoded run, plus one word for the
//   terminating zero header (list_end_o) or for a header whose size nibble
//   exceeds eight (format_error_o). After either of those the decoder
//   ignores bytes until the next list_start_i.
//   Throughput is one byte per clock cycle while the input is not stalled.
//   The result appears in the cycle after its last byte is accepted; the work
//   for that byte is a single pass of lane shift, sign extension and a
//   64-bit add between the run state registers and the output register.
//   When the receiver stalls, the output register holds its word, and the
//   input is stalled only while that register is full and stalled, so any
//   byte, even one that produces no result, waits behind a stalled result.
//   Reset (rst_ni low, asynchronous) clears all run state, the running LCN
//   and VCN, and empties the output register; the decoder then waits for
//   a header byte.
module ntfs_run_list_decoder
  import ntfsrl_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ByteW-1:0]        run_byte_i,
  input  logic                    list_start_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [WordW-1:0]        run_length_o,
  output logic signed [WordW-1:0] lcn_delta_o,
  output logic signed [WordW-1:0] start_lcn_o,
  output logic                    is_sparse_o,
  output logic [WordW-1:0]        run_vcn_o,
  output logic                    list_end_o,
  output logic                    format_error_o
);

  // Run state.
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW-1:0] len_left_q, len_left_d;
  logic [CountW-1:0] off_left_q, off_left_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [WordW-1:0]  len_acc_q, len_acc_d;
  logic [WordW-1:0]  dlt_acc_q, dlt_acc_d;
  logic [WordW-1:0]  prev_lcn_q, prev_lcn_d;
  logic [WordW-1:0]  next_vcn_q, next_vcn_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  run_length_q, run_length_d;
  logic [WordW-1:0]  lcn_delta_q, lcn_delta_d;
  logic [WordW-1:0]  start_lcn_q, start_lcn_d;
  logic              is_sparse_q, is_sparse_d;
  logic [WordW-1:0]  run_vcn_q, run_vcn_d;
  logic              list_end_q, list_end_d;
  logic              format_error_q, format_error_d;

  logic              in_acc;
  logic              res_valid;
  logic [PhaseW-1:0] cur_phase;
  logic [CountW-1:0] lsz, osz;
  logic [WordW-1:0]  byte_sh;
  logic [WordW-1:0]  len_new, dlt_new, dlt_ext, ext_mask, lcn_sum;
  logic [PosW-1:0]   pos_inc;
  logic [CountW-1:0] len_dec, off_dec;

  // The input stalls only while a finished word is waiting and stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign cur_phase = list_start_i ? PH_HEADER : phase_q;
  assign lsz       = run_byte_i[CountW-1:0];
  assign osz       = run_byte_i[ByteW-1:CountW];

  // Place the byte in its lane of the little-endian accumulators.
  assign byte_sh = {{(WordW-ByteW){1'b0}}, run_byte_i} << {pos_q, 3'b000};
  assign len_new = len_acc_q | byte_sh;
  assign dlt_new = dlt_acc_q | byte_sh;
  assign pos_inc = pos_q + 1'b1;
  assign len_dec = len_left_q - 1'b1;
  assign off_dec = off_left_q - 1'b1;

  // Sign extension of the delta: the byte just placed is the top byte, so
  // every lane above it takes its sign bit. A full eight-byte delta needs none.
  always_comb begin
    ext_mask = '0;
    for (int k = 0; k < Lanes; k++) begin
      if (PosW'(k) > pos_q) begin
        ext_mask[k*ByteW +: ByteW] = {ByteW{run_byte_i[ByteW-1]}};
      end
    end
  end
  assign dlt_ext = dlt_new | ext_mask;
  assign lcn_sum = prev_lcn_q + dlt_ext;

  always_comb begin
    phase_d        = phase_q;
    len_left_d     = len_left_q;
    off_left_d     = off_left_q;
    pos_d          = pos_q;
    len_acc_d      = len_acc_q;
    dlt_acc_d      = dlt_acc_q;
    prev_lcn_d     = list_start_i ? '0 : prev_lcn_q;
    next_vcn_d     = list_start_i ? '0 : next_vcn_q;
    res_valid      = 1'b0;
    run_length_d   = '0;
    lcn_delta_d    = '0;
    start_lcn_d    = '0;
    is_sparse_d    = 1'b0;
    run_vcn_d      = '0;
    list_end_d     = 1'b0;
    format_error_d = 1'b0;

    unique case (cur_phase)
      PH_HEADER: begin
        if (run_byte_i == '0) begin
          res_valid  = 1'b1;
          list_end_d = 1'b1;
          phase_d    = PH_HALTED;
        end else if (lsz > SizeMax || osz > SizeMax) begin
          res_valid      = 1'b1;
          format_error_d = 1'b1;
          phase_d        = PH_HALTED;
        end else begin
          len_left_d = lsz;
          off_left_d = osz;
          pos_d      = '0;
          len_acc_d  = '0;
          dlt_acc_d  = '0;
          phase_d    = (lsz != '0) ? PH_LENGTH : PH_OFFSET;
        end
      end
      PH_LENGTH: begin
        len_acc_d  = len_new;
        pos_d      = pos_inc;
        len_left_d = len_dec;
        if (len_dec == '0) begin
          if (off_left_q == '0) begin
            // Sparse run: no delta bytes, LCN chain unchanged.
            res_valid    = 1'b1;
            run_length_d = len_new;
            is_sparse_d  = 1'b1;
            run_vcn_d    = next_vcn_q;
            next_vcn_d   = next_vcn_q + len_new;
            phase_d      = PH_HEADER;
          end else begin
            pos_d   = '0;
            phase_d = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        dlt_acc_d  = dlt_new;
        pos_d      = pos_inc;
        off_left_d = off_dec;
        if (off_dec == '0) begin
          res_valid    = 1'b1;
          dlt_acc_d    = dlt_ext;
          run_length_d = len_acc_q;
          lcn_delta_d  = dlt_ext;
          start_lcn_d  = lcn_sum;
          prev_lcn_d   = lcn_sum;
          run_vcn_d    = next_vcn_q;
          next_vcn_d   = next_vcn_q + len_acc_q;
          phase_d      = PH_HEADER;
        end
      end
      PH_HALTED: begin
        phase_d = PH_HALTED;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      len_left_q  <= '0;
      off_left_q  <= '0;
      pos_q       <= '0;
      len_acc_q   <= '0;
      dlt_acc_q   <= '0;
      prev_lcn_q  <= '0;
      next_vcn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q    <= phase_d;
        len_left_q <= len_left_d;
        off_left_q <= off_left_d;
        pos_q      <= pos_d;
        len_acc_q  <= len_acc_d;
        dlt_acc_q  <= dlt_acc_d;
        prev_lcn_q <= prev_lcn_d;
        next_vcn_q <= next_vcn_d;
      end
    end
  end

  // Result payload: loaded only with a new word, held while stalled.
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      run_length_q   <= run_length_d;
      lcn_delta_q    <= lcn_delta_d;
      start_lcn_q    <= start_lcn_d;
      is_sparse_q    <= is_sparse_d;
      run_vcn_q      <= run_vcn_d;
      list_end_q     <= list_end_d;
      format_error_q <= format_error_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign run_length_o   = run_length_q;
  assign lcn_delta_o    = lcn_delta_q;
  assign start_lcn_o    = start_lcn_q;
  assign is_sparse_o    = is_sparse_q;
  assign run_vcn_o      = run_vcn_q;
  assign list_end_o     = list_end_q;
  assign format_error_o = format_error_q;

endmodule

[rtl/core/ntfsrl_checker.sv]
// Port-level checker for the NTFS run list decoder, bound to its top level.
// Depends on ntfsrl_pkg and ntfs_run_list_decoder.
module ntfsrl_checker
  import ntfsrl_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [WordW-1:0]        run_length_o,
  input logic signed [WordW-1:0] lcn_delta_o,
  input logic signed [WordW-1:0] start_lcn_o,
  input logic                    is_sparse_o,
  input logic [WordW-1:0]        run_vcn_o,
  input logic                    list_end_o,
  input logic                    format_error_o
);

  // A stalled word stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(run_length_o)
      && $stable(start_lcn_o) && $stable(run_vcn_o) && $stable(list_end_o))
    else $error("stalled output word changed");

  // The input is held back only by a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting output word");

  // A word is a run, a list end or an error, never two of the kinds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({is_sparse_o, list_end_o, format_error_o}))
    else $error("conflicting result flags");

  // Sparse runs carry no LCN information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_sparse_o |-> lcn_delta_o == '0 && start_lcn_o == '0)
    else $error("sparse run with nonzero LCN");

  // List end and error words carry no run length, VCN or start LCN.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (list_end_o || format_error_o) |->
      run_length_o == '0 && run_vcn_o == '0 && start_lcn_o == '0)
    else $error("terminal word with nonzero fields");

endmodule

bind ntfs_run_list_decoder ntfsrl_checker u_ntfsrl_checker (.*);
